/* rtl/sorted_datetime_table_assert.svh */
// Assertion macros used by the sorted date-time table top level.
`ifndef SORTED_DATETIME_TABLE_ASSERT_SVH
`define SORTED_DATETIME_TABLE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SDT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sdt_pkg.sv */
// Types and codes shared by the sorted date-time table modules.
`timescale 1ns / 1ps

package sdt_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 6;
   localparam int OUT_W = 6;

   typedef enum logic [2:0] {
      OP_SORTED_INSERT = 3'd0,
      OP_INSERT_AT     = 3'd1,
      OP_REMOVE_KEY    = 3'd2,
      OP_REMOVE_AT     = 3'd3,
      OP_FIND          = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_BADPOS  = 2'd3
   } status_type;

   typedef logic [KEY_W-1:0] key_type;

   // Shift command broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic rem;
   } cmd_type;

   // Compare results a cell reports against the broadcast key.
   typedef struct packed {
      logic lt;
      logic eq;
   } flag_type;

endpackage

/* rtl/sorted_datetime_table.sv */
// Top level of the sorted date-time table: a row of shifting slot cells and a sequencer.
//
// Usage: one item enters on the req_ channel and carries an opcode (req_tuser) and a
// date-time key plus a position (req_tdata). Exactly one result item leaves on the
// rsp_ channel per input item, carrying status, slot index and entry count.
// Every slot compares itself with the broadcast key in parallel, and an insert or a
// removal moves all slots behind the target by one place at once.
// Sequence: an accepted item runs through compare, search and apply states; its result
// is written to the output register when the apply step fires with the output free.
// Items are taken one at a time: each passes the compare and priority search stages
// in turn before the table is updated, and the next item waits until it is done.
// req_tready is high only while no item is in progress; a new item may be taken while
// the previous result still waits in the output register.
// If the receiver stalls, the item in the apply step waits and the table is not
// changed until the output register is free.
// Reset empties the table (the count goes to zero); slot contents are not cleared.
`timescale 1ns / 1ps
`include "sorted_datetime_table_assert.svh"

module sorted_datetime_table #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] key_year, [15:12] key_month, [20:16] key_day, [25:21] key_hour,
   // [31:26] key_minute, [37:32] position, [39:38] zero
   input  logic [39:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [7:2] slot_index, [13:8] entry_count, [15:14] zero
   output logic [15:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > sdt_pkg::POS_W) ? CNT_W : sdt_pkg::POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_SRCH,
      S_APPLY
   } state_type;

   state_type                   state_ff;
   sdt_pkg::opcode_type         op_ff;
   sdt_pkg::key_type            key_ff;
   logic [sdt_pkg::POS_W-1:0]   pos_ff;
   logic [CNT_W-1:0]            count_ff;
   logic                        rsp_valid_ff;
   sdt_pkg::status_type         rsp_status_ff;
   logic [sdt_pkg::OUT_W-1:0]   rsp_slot_ff;
   logic [sdt_pkg::OUT_W-1:0]   rsp_count_ff;

   sdt_pkg::key_type            entry_w [CAPACITY];
   sdt_pkg::flag_type           flag_w  [CAPACITY];
   logic [SLOT_W-1:0]           hit_idx;
   logic                        hit_any;

   sdt_pkg::cmd_type            cmd_w;
   sdt_pkg::cmd_type            cell_cmd;
   sdt_pkg::status_type         status_w;
   logic [CNT_W-1:0]            target_w;
   logic [CNT_W-1:0]            slot_w;
   logic [CNT_W-1:0]            count_in;
   logic [CMP_W-1:0]            slot_wide;
   logic [CMP_W-1:0]            count_wide;
   logic [CMP_W-1:0]            pos_wide;
   logic [CMP_W-1:0]            cur_wide;
   logic                        req_accept;
   logic                        out_free;
   logic                        fire;
   logic                        full;
   logic [CNT_W-1:0]            hit_cnt;

   assign req_tready = state_ff == S_IDLE;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = (state_ff == S_APPLY) && out_free;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      sdt_pkg::key_type left_w;
      sdt_pkg::key_type right_w;
      if (g == 0) begin : g_first
         assign left_w = key_ff;
      end else begin : g_mid_l
         assign left_w = entry_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = entry_w[g];
      end else begin : g_mid_r
         assign right_w = entry_w[g+1];
      end
      sdt_cell #(
         .SLOT  (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .target      (target_w),
         .key         (key_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[g]),
         .flags       (flag_w[g])
      );
   end

   sdt_find #(
      .CAPACITY (CAPACITY),
      .SLOT_W   (SLOT_W),
      .CNT_W    (CNT_W)
   ) u_find (
      .clock   (clock),
      .flags   (flag_w),
      .count   (count_ff),
      .sorted  (op_ff == sdt_pkg::OP_SORTED_INSERT),
      .hit_idx (hit_idx),
      .hit_any (hit_any)
   );

   assign hit_cnt  = CNT_W'(hit_idx);
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign pos_wide = CMP_W'(pos_ff);
   assign cur_wide = CMP_W'(count_ff);

   always_comb begin
      cmd_w    = '0;
      status_w = sdt_pkg::ST_OK;
      target_w = '0;
      unique case (op_ff)
         sdt_pkg::OP_SORTED_INSERT: begin
            if (full) begin
               status_w = sdt_pkg::ST_FULL;
            end else begin
               cmd_w.ins = 1'b1;
               target_w  = hit_any ? hit_cnt : count_ff;
            end
         end
         sdt_pkg::OP_INSERT_AT: begin
            priority if (full) begin
               status_w = sdt_pkg::ST_FULL;
            end else if (pos_wide > cur_wide) begin
               status_w = sdt_pkg::ST_BADPOS;
            end else begin
               cmd_w.ins = 1'b1;
               target_w  = CNT_W'(pos_wide);
            end
         end
         sdt_pkg::OP_REMOVE_KEY: begin
            if (!hit_any) begin
               status_w = sdt_pkg::ST_MISSING;
            end else begin
               cmd_w.rem = 1'b1;
               target_w  = hit_cnt;
            end
         end
         sdt_pkg::OP_REMOVE_AT: begin
            if (pos_wide >= cur_wide) begin
               status_w = sdt_pkg::ST_BADPOS;
            end else begin
               cmd_w.rem = 1'b1;
               target_w  = CNT_W'(pos_wide);
            end
         end
         sdt_pkg::OP_FIND: begin
            if (!hit_any) begin
               status_w = sdt_pkg::ST_MISSING;
            end else begin
               target_w = hit_cnt;
            end
         end
         default: begin
            status_w = sdt_pkg::ST_OK;
         end
      endcase
   end

   // Error results and unused opcodes report slot zero.
   assign slot_w   = (status_w == sdt_pkg::ST_OK) ? target_w : '0;
   assign count_in = cmd_w.ins ? count_ff + 1'b1 : (cmd_w.rem ? count_ff - 1'b1 : count_ff);
   assign cell_cmd = fire ? cmd_w : '0;
   assign slot_wide  = CMP_W'(slot_w);
   assign count_wide = CMP_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_SRCH;
            end
            S_SRCH: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (out_free) begin
                  count_ff     <= count_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (req_accept) begin
         op_ff  <= sdt_pkg::opcode_type'(req_tuser);
         key_ff <= {req_tdata[11:0], req_tdata[15:12], req_tdata[20:16],
                    req_tdata[25:21], req_tdata[31:26]};
         pos_ff <= req_tdata[37:32];
      end
      if (fire) begin
         rsp_status_ff <= status_w;
         rsp_slot_ff   <= slot_wide[sdt_pkg::OUT_W-1:0];
         rsp_count_ff  <= count_wide[sdt_pkg::OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_slot_ff, rsp_status_ff};

   `SDT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count exceeds capacity")
   `SDT_ASSERT_NEXT(a_insert_grows, cell_cmd.ins, count_ff == $past(count_ff) + 1'b1,
      "insert did not add one entry")
   `SDT_ASSERT_SAME(a_error_slot, rsp_valid_ff && rsp_status_ff != sdt_pkg::ST_OK,
      rsp_slot_ff == '0, "error result carries a nonzero slot")
   `SDT_ASSERT_NEXT(a_one_in_flight, req_accept, !req_tready,
      "second item accepted while one is in progress")

endmodule

/* rtl/sdt_cell.sv */
// One table slot: holds an entry, compares it with the key and shifts with its neighbors.
`timescale 1ns / 1ps

module sdt_cell #(
   parameter int SLOT  = 0,
   parameter int CNT_W = 6
) (
   input  logic              clock,
   input  sdt_pkg::cmd_type  cmd,
   input  logic [CNT_W-1:0]  target,
   input  sdt_pkg::key_type  key,
   input  sdt_pkg::key_type  left_entry,
   input  sdt_pkg::key_type  right_entry,
   output sdt_pkg::key_type  entry,
   output sdt_pkg::flag_type flags
);

   localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(SLOT);

   sdt_pkg::key_type  entry_ff;
   sdt_pkg::flag_type flags_ff;

   always_ff @(posedge clock) begin
      flags_ff.lt <= entry_ff < key;
      flags_ff.eq <= entry_ff == key;
      if (cmd.ins) begin
         if (MY_SLOT > target) begin
            entry_ff <= left_entry;
         end else if (MY_SLOT == target) begin
            entry_ff <= key;
         end
      end else if (cmd.rem && MY_SLOT >= target) begin
         entry_ff <= right_entry;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

/* rtl/sdt_find.sv */
// Registered priority search for the lowest occupied slot that flags a hit.
`timescale 1ns / 1ps

module sdt_find #(
   parameter int CAPACITY = 32,
   parameter int SLOT_W   = 5,
   parameter int CNT_W    = 6
) (
   input  logic              clock,
   input  sdt_pkg::flag_type flags [CAPACITY],
   input  logic [CNT_W-1:0]  count,
   input  logic              sorted,
   output logic [SLOT_W-1:0] hit_idx,
   output logic              hit_any
);

   logic [CAPACITY-1:0] hit;
   logic [SLOT_W-1:0]   idx_w;
   logic                any_w;
   logic [SLOT_W-1:0]   idx_ff;
   logic                any_ff;

   // A sorted insert stops at the first entry not below the key; remove and find stop at a match.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_hit
      assign hit[g] = (CNT_W'(g) < count) && (sorted ? !flags[g].lt : flags[g].eq);
   end

   always_comb begin
      idx_w = '0;
      any_w = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) begin
            idx_w = SLOT_W'(i);
            any_w = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_w;
      any_ff <= any_w;
   end

   assign hit_idx = idx_ff;
   assign hit_any = any_ff;

endmodule

/* tb/datetime_table_checker.sv */
// Checker for the sorted date-time table: predicts every result item and compares it.
`timescale 1ns / 1ps

module datetime_table_checker
   import sdt_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [11:0] key_year, [15:12] key_month, [20:16] key_day, [25:21] key_hour,
   // [31:26] key_minute, [37:32] position, [39:38] zero
   input  logic [39:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [7:2] slot_index, [13:8] entry_count, [15:14] zero
   input  logic [15:0] rsp_tdata,
   output int          failures,
   output int          pending
);

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [5:0]  held;
   } table_result_t;

   key_type       shadow_slots [CAPACITY];
   int            shadow_count;
   table_result_t awaited_results [$];
   int            printed;

   initial begin
      failures     = 0;
      pending      = 0;
      printed      = 0;
      shadow_count = 0;
   end

   task automatic report_mismatch(input string what);
      // Keep the log short when the block is badly broken; every mismatch still counts.
      if (printed < 100) begin
         $display("%0t ns checker: %s", $time, what);
         printed++;
      end
      failures++;
   endtask

   task automatic open_slot(input int at, input key_type key);
      for (int i = shadow_count; i > at; i--) begin
         shadow_slots[i] = shadow_slots[i-1];
      end
      shadow_slots[at] = key;
      shadow_count++;
   endtask

   task automatic close_slot(input int at);
      for (int i = at; i + 1 < shadow_count; i++) begin
         shadow_slots[i] = shadow_slots[i+1];
      end
      shadow_count--;
   endtask

   function automatic int first_equal(input key_type key);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_slots[i] == key) return i;
      end
      return -1;
   endfunction

   task automatic predict_table_op(input logic [2:0] op, input key_type key, input int pos,
                                   output table_result_t res);
      int at;
      res.status = ST_OK;
      at = 0;
      case (op)
         OP_SORTED_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // Stop at the first entry that is not smaller, so equal keys go after the new one.
               while (at < shadow_count && shadow_slots[at] < key) at++;
               open_slot(at, key);
            end
         end
         OP_INSERT_AT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (pos > shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               at = pos;
               open_slot(at, key);
            end
         end
         OP_REMOVE_KEY: begin
            at = first_equal(key);
            if (at < 0) begin
               res.status = ST_MISSING;
            end else begin
               close_slot(at);
            end
         end
         OP_REMOVE_AT: begin
            if (pos >= shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               at = pos;
               close_slot(at);
            end
         end
         OP_FIND: begin
            at = first_equal(key);
            if (at < 0) res.status = ST_MISSING;
         end
         default: ;
      endcase
      if (res.status != ST_OK) at = 0;
      res.slot = 6'(at);
      res.held = 6'(shadow_count);
   endtask

   always @(posedge clock) begin : watch
      table_result_t want;
      table_result_t got;
      table_result_t fresh;
      key_type       key;
      if (reset) begin
         shadow_count = 0;
         awaited_results.delete();
         pending = 0;
      end else begin
         // Results leave only after their item was accepted, so retire before predicting.
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.slot   = rsp_tdata[7:2];
            got.held   = rsp_tdata[13:8];
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result item with none expected (tdata %h)",
                                         rsp_tdata));
            end else begin
               want = awaited_results.pop_front();
               if (got.status != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.slot != want.slot)
                  report_mismatch($sformatf("slot_index %0d, expected %0d",
                                            got.slot, want.slot));
               if (got.held != want.held)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            got.held, want.held));
            end
         end
         if (req_tvalid && req_tready) begin
            key = {req_tdata[11:0], req_tdata[15:12], req_tdata[20:16],
                   req_tdata[25:21], req_tdata[31:26]};
            predict_table_op(req_tuser, key, int'(req_tdata[37:32]), fresh);
            awaited_results.push_back(fresh);
         end
         pending = awaited_results.size();
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the sorted date-time table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import sdt_pkg::*;

   localparam int CAPACITY = 32;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam int POOL_SIZE = 6;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } datetime_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [11:0] key_year, [15:12] key_month, [20:16] key_day, [25:21] key_hour,
   // [31:26] key_minute, [37:32] position, [39:38] zero
   logic [39:0] req_tdata;
   // [2:0] opcode
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [1:0] status, [7:2] slot_index, [13:8] entry_count, [15:14] zero
   logic [15:0] rsp_tdata;

   int          failures;
   int          pending;
   int          idle_pct;
   int          stall_pct;
   int          item_no;
   datetime_t   key_pool [POOL_SIZE];

   sorted_datetime_table #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   datetime_table_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
   end

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #5_000_000;
      $display("[sorted_datetime_table] ERROR");
      $finish;
   end

   function automatic datetime_t dt(input int y, input int mo, input int d, input int h,
                                    input int mi);
      datetime_t k;
      k.year   = 12'(y);
      k.month  = 4'(mo);
      k.day    = 5'(d);
      k.hour   = 5'(h);
      k.minute = 6'(mi);
      return k;
   endfunction

   function automatic datetime_t random_key();
      datetime_t k;
      int        r;
      r = $urandom_range(99);
      if (r < 40) begin
         // Reused keys make removals and finds hit entries that are really held.
         k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (r < 50) begin
         k.year   = $urandom_range(1) ? '1 : '0;
         k.month  = $urandom_range(1) ? '1 : '0;
         k.day    = $urandom_range(1) ? '1 : '0;
         k.hour   = $urandom_range(1) ? '1 : '0;
         k.minute = $urandom_range(1) ? '1 : '0;
      end else begin
         k.year   = 12'($urandom_range(4095));
         k.month  = 4'($urandom_range(15));
         k.day    = 5'($urandom_range(31));
         k.hour   = 5'(($urandom_range(99) < 5) ? $urandom_range(31) : $urandom_range(23));
         k.minute = 6'(($urandom_range(99) < 5) ? $urandom_range(63) : $urandom_range(59));
      end
      return k;
   endfunction

   function automatic logic [5:0] random_position();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 6'($urandom_range(8));
      if (r < 90) return 6'($urandom_range(CAPACITY + 1));
      return 6'($urandom_range(63));
   endfunction

   task automatic send_item(input logic [2:0] op, input datetime_t k, input logic [5:0] pos);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, pos, k.minute, k.hour, k.day, k.month, k.year};
      do @(posedge clock); while (!req_tready);
   endtask

   // The sender drops its valid while it waits, so no item is offered twice.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [2:0] op;
      int         r;
      bit         filling;
      // Alternate between stretches that fill the table and stretches that empty it.
      filling = ((item_no / 60) % 2) == 0;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 45)      op = OP_SORTED_INSERT;
         else if (r < 70) op = OP_INSERT_AT;
         else if (r < 80) op = OP_REMOVE_KEY;
         else if (r < 87) op = OP_REMOVE_AT;
         else if (r < 97) op = OP_FIND;
         else             op = OP_UNUSED_FIRST + 3'($urandom_range(2));
      end else begin
         if (r < 12)      op = OP_SORTED_INSERT;
         else if (r < 20) op = OP_INSERT_AT;
         else if (r < 50) op = OP_REMOVE_KEY;
         else if (r < 80) op = OP_REMOVE_AT;
         else if (r < 95) op = OP_FIND;
         else             op = OP_UNUSED_FIRST + 3'($urandom_range(2));
      end
      send_item(op, random_key(), random_position());
      item_no++;
   endtask

   initial begin : stimulus
      datetime_t zero_key;
      datetime_t max_key;
      zero_key = '0;
      max_key  = '1;
      key_pool[0] = zero_key;
      key_pool[1] = max_key;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = dt($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                          $urandom_range(23), $urandom_range(59));
      end
      item_no = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty-table errors, ordering, equal keys and the unused opcodes.
      send_item(OP_FIND, zero_key, 6'd0);
      send_item(OP_REMOVE_KEY, zero_key, 6'd0);
      send_item(OP_REMOVE_AT, zero_key, 6'd0);
      send_item(OP_INSERT_AT, max_key, 6'd1);
      send_item(OP_INSERT_AT, max_key, 6'd0);
      send_item(OP_SORTED_INSERT, zero_key, 6'd0);
      send_item(OP_SORTED_INSERT, zero_key, 6'd63);
      send_item(OP_SORTED_INSERT, dt(2024, 6, 15, 12, 30), 6'd0);
      send_item(OP_SORTED_INSERT, dt(2024, 6, 15, 12, 31), 6'd0);
      send_item(OP_SORTED_INSERT, dt(2024, 6, 15, 11, 59), 6'd0);
      send_item(OP_INSERT_AT, dt(1, 1, 1, 1, 1), 6'd6);
      send_item(OP_FIND, zero_key, 6'd0);
      send_item(OP_FIND, max_key, 6'd0);
      send_item(OP_FIND, dt(1, 1, 1, 1, 1), 6'd0);
      send_item(OP_FIND, dt(2024, 6, 15, 12, 29), 6'd0);
      send_item(OP_REMOVE_KEY, zero_key, 6'd0);
      send_item(OP_REMOVE_KEY, dt(4095, 15, 31, 31, 62), 6'd0);
      send_item(OP_REMOVE_AT, zero_key, 6'd6);
      send_item(OP_REMOVE_AT, zero_key, 6'd63);
      send_item(OP_INSERT_AT, zero_key, 6'd63);
      for (int k = 0; k < 3; k++) begin
         send_item(OP_UNUSED_FIRST + 3'(k), max_key, 6'd63);
      end
      send_item(OP_REMOVE_AT, zero_key, 6'd0);
      send_item(OP_REMOVE_AT, zero_key, 6'd4);

      // Random part in four handshake phases.
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         for (int n = 0; n < 250; n++) begin
            if (phase == 1 && n == 125) drain_results();
            send_random_item();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      drain_results();
      repeat (16) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("[sorted_datetime_table] OK");
      end else begin
         $display("[sorted_datetime_table] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/sdt_pkg.sv
rtl/sdt_cell.sv
rtl/sdt_find.sv
rtl/sorted_datetime_table.sv
tb/datetime_table_checker.sv
tb/testbench.sv
